// ----- hw/rtl/bms_pkg.sv -----
// Package for the blob moment statistics block: payload structs, widths and FSM codes.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package bms_pkg;

   localparam int COORD_BITS = 10;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int CHANNELS   = 3;
   localparam int CH_BITS    = 2;
   localparam int VAL_BITS   = 8;
   localparam int COUNT_BITS = 21;
   localparam int SUM_BITS   = 28;
   localparam int MOM_BITS   = 38;
   localparam int PROD_BITS  = VAL_BITS + COORD_BITS;
   localparam int AREA_BITS  = 2 * COORD_BITS + 1;
   localparam int FRAC_BITS  = 16;
   localparam int FILL_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS  = $clog2(FRAC_BITS);
   localparam logic [FILL_BITS-1:0] Q_ONE = FILL_BITS'(1) << FRAC_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [VAL_BITS-1:0]   intensity;
      logic [CH_BITS-1:0]    channel;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    blob_channel;
      logic [COORD_BITS-1:0] box_min_x;
      logic [EDGE_BITS-1:0]  box_max_x;
      logic [COORD_BITS-1:0] box_min_y;
      logic [EDGE_BITS-1:0]  box_max_y;
      logic [COUNT_BITS-1:0] pixel_count;
      logic [SUM_BITS-1:0]   intensity_total;
      logic [MOM_BITS-1:0]   row_moment;
      logic [MOM_BITS-1:0]   column_moment;
      logic [FILL_BITS-1:0]  fill_ratio;
   } rsp_type;

   // A finished blob as it leaves the accumulator, before the fill ratio is known.
   typedef struct packed {
      logic [CH_BITS-1:0]    blob_channel;
      logic [COORD_BITS-1:0] box_min_x;
      logic [EDGE_BITS-1:0]  box_max_x;
      logic [COORD_BITS-1:0] box_min_y;
      logic [EDGE_BITS-1:0]  box_max_y;
      logic [COUNT_BITS-1:0] pixel_count;
      logic [SUM_BITS-1:0]   intensity_total;
      logic [MOM_BITS-1:0]   row_moment;
      logic [MOM_BITS-1:0]   column_moment;
   } blob_record_type;

   typedef struct packed {
      logic            valid;
      blob_record_type rec;
   } blob_push_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_AREA,
      BACK_CHECK,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/blob_moment_statistics.sv -----
// Blob moment statistics: a pixel per cycle in while req_full is low, one result per
// finished blob out. A finished blob passes the two-entry queue, then the ratio unit
// (box area, saturation check, then a 16-step divider unless the ratio saturates)
// and the result register. The ratio unit works on one blob at a time; the queue
// absorbs short blobs. Reset is synchronous and empties everything.
`default_nettype none

module blob_moment_statistics (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire bms_pkg::req_type req_data,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output bms_pkg::rsp_type    rsp_data
);

   bms_pkg::blob_push_type   blob_push;
   bms_pkg::blob_record_type queue_head;
   logic                     queue_empty, queue_pop;

   bms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .queue_full (req_full),
      .req_data   (req_data),
      .blob_push  (blob_push)
   );

   bms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .blob_push (blob_push),
      .pop       (queue_pop),
      .full      (req_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   bms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.fill_ratio <= bms_pkg::Q_ONE)
      else $error("fill ratio above one");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.box_max_x > 11'(rsp_data.box_min_x)) &&
                     (rsp_data.box_max_y > 11'(rsp_data.box_min_y)))
      else $error("bounding box maximum not above minimum");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.pixel_count != '0)
      else $error("result with no pixels");

endmodule

`default_nettype wire

// ----- hw/rtl/bms_front.sv -----
// Pixel accumulator: bounding box, count, intensity sum and moments of the open blob.
// Depends on bms_pkg; hands each finished blob to bms_queue.
`default_nettype none

module bms_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   input  wire                     queue_full,
   input  wire bms_pkg::req_type   req_data,
   output bms_pkg::blob_push_type  blob_push
);

   logic                                in_blob_ff, in_blob_in;
   logic [bms_pkg::CH_BITS-1:0]         chan_ff, chan_in;
   logic [bms_pkg::COORD_BITS-1:0]      min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic [bms_pkg::EDGE_BITS-1:0]       max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic [bms_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic [bms_pkg::SUM_BITS-1:0]        sum_ff, sum_in;
   logic [bms_pkg::MOM_BITS-1:0]        row_ff, row_in, col_ff, col_in;

   logic                                accept, first;
   logic [bms_pkg::EDGE_BITS-1:0]       x_end, y_end;
   logic [bms_pkg::PROD_BITS-1:0]       prod_y, prod_x;
   logic [bms_pkg::COUNT_BITS:0]        count_sum;
   logic [bms_pkg::SUM_BITS:0]          int_sum;
   logic [bms_pkg::MOM_BITS:0]          row_sum, col_sum;

   assign accept = req_push && !queue_full;
   assign first  = !in_blob_ff;
   assign x_end  = {1'b0, req_data.x} + bms_pkg::EDGE_BITS'(1);
   assign y_end  = {1'b0, req_data.y} + bms_pkg::EDGE_BITS'(1);
   assign prod_y = req_data.intensity * req_data.y;
   assign prod_x = req_data.intensity * req_data.x;

   always_comb begin
      if (first) begin
         chan_in  = (32'(req_data.channel) >= bms_pkg::CHANNELS) ?
                    bms_pkg::CH_BITS'(bms_pkg::CHANNELS - 1) : req_data.channel;
         min_x_in = req_data.x;
         max_x_in = x_end;
         min_y_in = req_data.y;
         max_y_in = y_end;
      end else begin
         chan_in  = chan_ff;
         min_x_in = (req_data.x < min_x_ff) ? req_data.x : min_x_ff;
         max_x_in = (x_end > max_x_ff) ? x_end : max_x_ff;
         min_y_in = (req_data.y < min_y_ff) ? req_data.y : min_y_ff;
         max_y_in = (y_end > max_y_ff) ? y_end : max_y_ff;
      end
      // A new blob starts its sums from zero; every sum saturates at all ones.
      count_sum = (first ? '0 : {1'b0, count_ff}) + (bms_pkg::COUNT_BITS + 1)'(1);
      int_sum   = (first ? '0 : {1'b0, sum_ff}) + (bms_pkg::SUM_BITS + 1)'(req_data.intensity);
      row_sum   = (first ? '0 : {1'b0, row_ff}) + (bms_pkg::MOM_BITS + 1)'(prod_y);
      col_sum   = (first ? '0 : {1'b0, col_ff}) + (bms_pkg::MOM_BITS + 1)'(prod_x);
      count_in  = count_sum[bms_pkg::COUNT_BITS] ? '1 : count_sum[bms_pkg::COUNT_BITS-1:0];
      sum_in    = int_sum[bms_pkg::SUM_BITS] ? '1 : int_sum[bms_pkg::SUM_BITS-1:0];
      row_in    = row_sum[bms_pkg::MOM_BITS] ? '1 : row_sum[bms_pkg::MOM_BITS-1:0];
      col_in    = col_sum[bms_pkg::MOM_BITS] ? '1 : col_sum[bms_pkg::MOM_BITS-1:0];
      in_blob_in = !req_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_blob_ff <= 1'b0;
      end else if (accept) begin
         in_blob_ff <= in_blob_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff  <= chan_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      blob_push.valid                = accept && req_data.last;
      blob_push.rec.blob_channel     = chan_in;
      blob_push.rec.box_min_x        = min_x_in;
      blob_push.rec.box_max_x        = max_x_in;
      blob_push.rec.box_min_y        = min_y_in;
      blob_push.rec.box_max_y        = max_y_in;
      blob_push.rec.pixel_count      = count_in;
      blob_push.rec.intensity_total  = sum_in;
      blob_push.rec.row_moment       = row_in;
      blob_push.rec.column_moment    = col_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bms_queue.sv -----
// Two-entry queue of finished blob records between the accumulator and the ratio unit.
// Depends on bms_pkg.
`default_nettype none

module bms_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  wire bms_pkg::blob_push_type   blob_push,
   input  wire                           pop,
   output logic                          full,
   output logic                          empty,
   output bms_pkg::blob_record_type      head
);

   bms_pkg::blob_record_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign do_push = blob_push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= blob_push.rec;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bms_back.sv -----
// Fill ratio unit and result register: box area, then a bit-serial saturating division.
// Depends on bms_pkg; takes records from bms_queue.
`default_nettype none

module bms_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          queue_empty,
   input  wire bms_pkg::blob_record_type queue_head,
   output logic                         queue_pop,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output bms_pkg::rsp_type             rsp_data
);

   bms_pkg::back_state_type            state_ff, state_in;
   bms_pkg::blob_record_type           rec_ff;
   logic [bms_pkg::AREA_BITS-1:0]      area_ff, rem_ff, rem_in;
   logic [bms_pkg::FILL_BITS-1:0]      quo_ff, quo_in;
   logic [bms_pkg::STEP_BITS-1:0]      step_ff;
   bms_pkg::rsp_type                   out_ff;
   logic                               out_valid_ff, out_valid_in;

   logic [bms_pkg::EDGE_BITS-1:0]      width, height;
   logic [2*bms_pkg::EDGE_BITS-1:0]    area_full;
   logic [bms_pkg::AREA_BITS:0]        shifted;
   logic                               fits, saturate, load_out, out_taken;

   assign width     = rec_ff.box_max_x - bms_pkg::EDGE_BITS'(rec_ff.box_min_x);
   assign height    = rec_ff.box_max_y - bms_pkg::EDGE_BITS'(rec_ff.box_min_y);
   assign area_full = width * height;
   // Count not below the area means the ratio is at least one.
   assign saturate  = (area_ff == '0) ||
                      (bms_pkg::AREA_BITS'(rec_ff.pixel_count) >= area_ff);
   assign shifted   = {rem_ff, 1'b0};
   assign fits      = shifted >= {1'b0, area_ff};
   assign out_taken = rsp_pop && out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bms_pkg::BACK_IDLE:  if (!queue_empty) state_in = bms_pkg::BACK_AREA;
         bms_pkg::BACK_AREA:  state_in = bms_pkg::BACK_CHECK;
         bms_pkg::BACK_CHECK: state_in = saturate ? bms_pkg::BACK_DONE : bms_pkg::BACK_DIV;
         bms_pkg::BACK_DIV:   if (step_ff == '1) state_in = bms_pkg::BACK_DONE;
         bms_pkg::BACK_DONE:  if (!out_valid_ff || rsp_pop) state_in = bms_pkg::BACK_IDLE;
         default:             state_in = bms_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      queue_pop = 1'b0;
      load_out  = 1'b0;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      unique case (state_ff)
         bms_pkg::BACK_IDLE:  queue_pop = !queue_empty;
         bms_pkg::BACK_AREA:  ;
         bms_pkg::BACK_CHECK: begin
            rem_in = bms_pkg::AREA_BITS'(rec_ff.pixel_count);
            quo_in = saturate ? bms_pkg::Q_ONE : '0;
         end
         bms_pkg::BACK_DIV: begin
            rem_in = fits ? bms_pkg::AREA_BITS'(shifted - {1'b0, area_ff})
                          : shifted[bms_pkg::AREA_BITS-1:0];
            quo_in = {quo_ff[bms_pkg::FILL_BITS-2:0], fits};
         end
         bms_pkg::BACK_DONE:  load_out = !out_valid_ff || rsp_pop;
         default:             ;
      endcase
      out_valid_in = load_out ? 1'b1 : (out_taken ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bms_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= (state_ff == bms_pkg::BACK_DIV) ? step_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rec_ff <= queue_head;
      end
      if (state_ff == bms_pkg::BACK_AREA) begin
         area_ff <= area_full[bms_pkg::AREA_BITS-1:0];
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (load_out) begin
         out_ff.blob_channel    <= rec_ff.blob_channel;
         out_ff.box_min_x       <= rec_ff.box_min_x;
         out_ff.box_max_x       <= rec_ff.box_max_x;
         out_ff.box_min_y       <= rec_ff.box_min_y;
         out_ff.box_max_y       <= rec_ff.box_max_y;
         out_ff.pixel_count     <= rec_ff.pixel_count;
         out_ff.intensity_total <= rec_ff.intensity_total;
         out_ff.row_moment      <= rec_ff.row_moment;
         out_ff.column_moment   <= rec_ff.column_moment;
         out_ff.fill_ratio      <= quo_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
